// ----- rtl/fop_pkg.sv -----
// Shared types, character codes and tag codes for the FIX order line parser.
// No dependencies; imported by every module in rtl/.
package fop_pkg;

    // Field sizes
    localparam int ID_CHARS          = 8;
    localparam int SYMBOL_CHARS      = 8;
    localparam int PRICE_CHARS       = 31;
    localparam int PRICE_FRAC_DIGITS = 4;

    localparam int FRAC_W  = $clog2(PRICE_FRAC_DIGITS + 2);
    localparam int SCALE_W = 4 * PRICE_FRAC_DIGITS + 1;
    localparam int PROD_W  = 48 + SCALE_W;

    // Characters
    localparam logic [7:0] CH_NL   = 8'd10;
    localparam logic [7:0] CH_EQ   = 8'd61;
    localparam logic [7:0] CH_BAR  = 8'd124;
    localparam logic [7:0] CH_ONE  = 8'd49;
    localparam logic [7:0] CH_ZERO = 8'd48;
    localparam logic [7:0] CH_NINE = 8'd57;
    localparam logic [7:0] CH_SP   = 8'd32;
    localparam logic [7:0] CH_TAB  = 8'd9;
    localparam logic [7:0] CH_CR   = 8'd13;
    localparam logic [7:0] CH_PLUS = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_DOT  = 8'd46;

    // Two-character tags, first character in the low byte
    localparam logic [15:0] TAG_CLORDID = 16'h3131;  // 11
    localparam logic [15:0] TAG_SYMBOL  = 16'h3535;  // 55
    localparam logic [15:0] TAG_SIDE    = 16'h3435;  // 54
    localparam logic [15:0] TAG_PRICE   = 16'h3434;  // 44
    localparam logic [15:0] TAG_QTY     = 16'h3833;  // 38

    // Side codes
    localparam logic [1:0] SIDE_NONE = 2'd0;
    localparam logic [1:0] SIDE_BUY  = 2'd1;
    localparam logic [1:0] SIDE_SELL = 2'd2;

    localparam logic [47:0] PRICE_CAP = 48'h8000_0000_0000;
    localparam logic [47:0] PRICE_MAX = 48'h7FFF_FFFF_FFFF;

    // One finished line, before price scaling
    typedef struct packed {
        logic [63:0]       id_text;
        logic [3:0]        id_length;
        logic [63:0]       symbol_text;
        logic [3:0]        symbol_length;
        logic [1:0]        side;
        logic [47:0]       price_mag;
        logic              price_neg;
        logic [FRAC_W-1:0] price_frac;
        logic [31:0]       quantity;
    } t_line;

    // 10 ** (PRICE_FRAC_DIGITS - frac)
    function automatic logic [SCALE_W-1:0] frac_scale(input logic [FRAC_W-1:0] frac);
        logic [SCALE_W-1:0] p;
        p = SCALE_W'(1);
        for (int i = 0; i < PRICE_FRAC_DIGITS; i++) begin
            if (FRAC_W'(i) >= frac) begin
                p = SCALE_W'(p * 10);
            end
        end
        return p;
    endfunction

endpackage

// ----- rtl/fop_scan.sv -----
// Per-byte tag/value scanner: keeps the state of the current line and
// registers a finished line for the output stage. Depends on fop_pkg.
module fop_scan
    import fop_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_byte_req,
    input  logic        i_end_of_stream,
    output logic        o_line_valid,
    input  logic        i_line_ready,
    output t_line       o_line
);

    // Line state
    logic              r_in_value, n_in_value;
    logic [1:0]        r_tag_count, n_tag_count;
    logic [15:0]       r_tag_first_two, n_tag_first_two;
    logic [5:0]        r_value_count, n_value_count;
    logic [63:0]       r_id_store, n_id_store;
    logic [3:0]        r_id_count, n_id_count;
    logic [63:0]       r_symbol_store, n_symbol_store;
    logic [3:0]        r_symbol_count, n_symbol_count;
    logic [1:0]        r_side_seen, n_side_seen;
    logic [47:0]       r_price_accum, n_price_accum;
    logic              r_ph_started, n_ph_started;
    logic              r_ph_neg, n_ph_neg;
    logic              r_ph_point, n_ph_point;
    logic              r_ph_stop, n_ph_stop;
    logic [FRAC_W-1:0] r_price_frac, n_price_frac;
    logic [31:0]       r_quantity_accum, n_quantity_accum;
    logic              r_line_nonempty, n_line_nonempty;

    logic              r_line_valid;
    t_line             r_line;

    logic        accept;
    logic        line_done;
    logic        tag2;
    logic [7:0]  ch;
    logic        is_blank, is_digit;
    logic [3:0]  digit;
    logic [51:0] price_times_ten;
    logic [47:0] price_step;
    logic [31:0] ch_sext;

    assign ch        = i_byte_req;
    assign accept    = i_valid && o_ready;
    assign line_done = (ch == CH_NL) || i_end_of_stream;
    assign o_ready   = !r_line_valid || i_line_ready;
    assign tag2      = (r_tag_count == 2'd2);

    // Character classes and accumulate steps
    assign is_blank = (ch == CH_SP) || ((ch >= CH_TAB) && (ch <= CH_CR));
    assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign digit    = 4'(ch - CH_ZERO);
    assign price_times_ten = {1'b0, r_price_accum, 3'b000} + {3'b000, r_price_accum, 1'b0}
                           + 52'(digit);
    assign price_step = (price_times_ten > 52'(PRICE_CAP)) ? PRICE_CAP : price_times_ten[47:0];
    assign ch_sext = {{24{ch[7]}}, ch};

    // Next line state for one byte
    always_comb begin
        n_in_value       = r_in_value;
        n_tag_count      = r_tag_count;
        n_tag_first_two  = r_tag_first_two;
        n_value_count    = r_value_count;
        n_id_store       = r_id_store;
        n_id_count       = r_id_count;
        n_symbol_store   = r_symbol_store;
        n_symbol_count   = r_symbol_count;
        n_side_seen      = r_side_seen;
        n_price_accum    = r_price_accum;
        n_ph_started     = r_ph_started;
        n_ph_neg         = r_ph_neg;
        n_ph_point       = r_ph_point;
        n_ph_stop        = r_ph_stop;
        n_price_frac     = r_price_frac;
        n_quantity_accum = r_quantity_accum;
        n_line_nonempty  = r_line_nonempty;

        if (ch != CH_NL) begin
            n_line_nonempty = 1'b1;
            if (r_in_value) begin
                if (ch == CH_BAR) begin
                    // value closed, next tag begins
                    n_in_value      = 1'b0;
                    n_tag_count     = 2'd0;
                    n_tag_first_two = 16'd0;
                    n_value_count   = 6'd0;
                end else begin
                    if (tag2) begin
                        case (r_tag_first_two)
                            TAG_CLORDID: begin
                                if (r_id_count < 4'(ID_CHARS)) begin
                                    n_id_store = r_id_store
                                               | ({56'd0, ch} << {r_id_count[2:0], 3'b000});
                                    n_id_count = r_id_count + 4'd1;
                                end
                            end
                            TAG_SYMBOL: begin
                                if (r_symbol_count < 4'(SYMBOL_CHARS)) begin
                                    n_symbol_store = r_symbol_store
                                        | ({56'd0, ch} << {r_symbol_count[2:0], 3'b000});
                                    n_symbol_count = r_symbol_count + 4'd1;
                                end
                            end
                            TAG_SIDE: begin
                                if ((r_value_count == 6'd0) && (ch == CH_ONE)) begin
                                    n_side_seen = SIDE_BUY;
                                end
                            end
                            TAG_PRICE: begin
                                if ((r_value_count < 6'(PRICE_CHARS)) && !r_ph_stop) begin
                                    if (!r_ph_started && is_blank) begin
                                        // leading blank skipped
                                    end else if (!r_ph_started
                                                 && ((ch == CH_PLUS) || (ch == CH_MINUS))) begin
                                        n_ph_started = 1'b1;
                                        n_ph_neg     = (ch == CH_MINUS);
                                    end else if (is_digit) begin
                                        n_ph_started = 1'b1;
                                        if (!r_ph_point) begin
                                            n_price_accum = price_step;
                                        end else if (r_price_frac
                                                     < FRAC_W'(PRICE_FRAC_DIGITS)) begin
                                            n_price_frac  = r_price_frac + FRAC_W'(1);
                                            n_price_accum = price_step;
                                        end
                                    end else if ((ch == CH_DOT) && !r_ph_point) begin
                                        n_ph_started = 1'b1;
                                        n_ph_point   = 1'b1;
                                    end else begin
                                        n_ph_stop = 1'b1;
                                    end
                                end
                            end
                            TAG_QTY: begin
                                n_quantity_accum = {r_quantity_accum[28:0], 3'b000}
                                                 + {r_quantity_accum[30:0], 1'b0}
                                                 + ch_sext - 32'(CH_ZERO);
                            end
                            default: begin
                            end
                        endcase
                    end
                    if (r_value_count != 6'd63) begin
                        n_value_count = r_value_count + 6'd1;
                    end
                end
            end else if (ch == CH_EQ) begin
                // value begins; a known tag restarts its field
                n_in_value    = 1'b1;
                n_value_count = 6'd0;
                if (tag2) begin
                    case (r_tag_first_two)
                        TAG_CLORDID: begin
                            n_id_store = 64'd0;
                            n_id_count = 4'd0;
                        end
                        TAG_SYMBOL: begin
                            n_symbol_store = 64'd0;
                            n_symbol_count = 4'd0;
                        end
                        TAG_SIDE: begin
                            n_side_seen = SIDE_SELL;
                        end
                        TAG_PRICE: begin
                            n_price_accum = 48'd0;
                            n_ph_started  = 1'b0;
                            n_ph_neg      = 1'b0;
                            n_ph_point    = 1'b0;
                            n_ph_stop     = 1'b0;
                            n_price_frac  = '0;
                        end
                        TAG_QTY: begin
                            n_quantity_accum = 32'd0;
                        end
                        default: begin
                        end
                    endcase
                end
            end else begin
                // tag character
                if (r_tag_count == 2'd0) begin
                    n_tag_first_two = {8'd0, ch};
                end else if (r_tag_count == 2'd1) begin
                    n_tag_first_two = {ch, r_tag_first_two[7:0]};
                end
                if (r_tag_count != 2'd3) begin
                    n_tag_count = r_tag_count + 2'd1;
                end
            end
        end
    end

    // Line state registers; cleared at every line end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && line_done)) begin
            r_in_value       <= 1'b0;
            r_tag_count      <= 2'd0;
            r_tag_first_two  <= 16'd0;
            r_value_count    <= 6'd0;
            r_id_store       <= 64'd0;
            r_id_count       <= 4'd0;
            r_symbol_store   <= 64'd0;
            r_symbol_count   <= 4'd0;
            r_side_seen      <= SIDE_NONE;
            r_price_accum    <= 48'd0;
            r_ph_started     <= 1'b0;
            r_ph_neg         <= 1'b0;
            r_ph_point       <= 1'b0;
            r_ph_stop        <= 1'b0;
            r_price_frac     <= '0;
            r_quantity_accum <= 32'd0;
            r_line_nonempty  <= 1'b0;
        end else if (accept) begin
            r_in_value       <= n_in_value;
            r_tag_count      <= n_tag_count;
            r_tag_first_two  <= n_tag_first_two;
            r_value_count    <= n_value_count;
            r_id_store       <= n_id_store;
            r_id_count       <= n_id_count;
            r_symbol_store   <= n_symbol_store;
            r_symbol_count   <= n_symbol_count;
            r_side_seen      <= n_side_seen;
            r_price_accum    <= n_price_accum;
            r_ph_started     <= n_ph_started;
            r_ph_neg         <= n_ph_neg;
            r_ph_point       <= n_ph_point;
            r_ph_stop        <= n_ph_stop;
            r_price_frac     <= n_price_frac;
            r_quantity_accum <= n_quantity_accum;
            r_line_nonempty  <= n_line_nonempty;
        end
    end

    // Finished-line register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_valid <= 1'b0;
        end else if (accept && line_done && n_line_nonempty) begin
            r_line_valid <= 1'b1;
        end else if (i_line_ready) begin
            r_line_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && line_done && n_line_nonempty) begin
            r_line.id_text       <= n_id_store;
            r_line.id_length     <= n_id_count;
            r_line.symbol_text   <= n_symbol_store;
            r_line.symbol_length <= n_symbol_count;
            r_line.side          <= n_side_seen;
            r_line.price_mag     <= n_price_accum;
            r_line.price_neg     <= n_ph_neg;
            r_line.price_frac    <= n_price_frac;
            r_line.quantity      <= n_quantity_accum;
        end
    end

    assign o_line_valid = r_line_valid;
    assign o_line       = r_line;

endmodule

// ----- rtl/fop_out.sv -----
// Output stage: scales the price to the fixed fraction width, saturates,
// applies the sign and holds the order for the consumer. Depends on fop_pkg.
module fop_out
    import fop_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_line_valid,
    output logic               o_line_ready,
    input  t_line              i_line,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [63:0]        o_id_text,
    output logic [3:0]         o_id_length,
    output logic [63:0]        o_symbol_text,
    output logic [3:0]         o_symbol_length,
    output logic [1:0]         o_side,
    output logic signed [47:0] o_price,
    output logic signed [31:0] o_quantity
);

    logic               r_valid;
    logic [63:0]        r_id_text;
    logic [3:0]         r_id_length;
    logic [63:0]        r_symbol_text;
    logic [3:0]         r_symbol_length;
    logic [1:0]         r_side;
    logic [47:0]        r_price;
    logic [31:0]        r_quantity;

    logic               load;
    logic [PROD_W-1:0]  scaled;
    logic [47:0]        mag;
    logic [47:0]        n_price;

    assign o_line_ready = !r_valid || i_ready;
    assign load         = i_line_valid && o_line_ready;

    // Pad missing fraction digits, saturate, then sign
    assign scaled = PROD_W'(i_line.price_mag) * PROD_W'(frac_scale(i_line.price_frac));
    assign mag    = (scaled > PROD_W'(PRICE_CAP)) ? PRICE_CAP : scaled[47:0];

    always_comb begin
        if (i_line.price_neg) begin
            n_price = 48'd0 - mag;
        end else if (mag > PRICE_MAX) begin
            n_price = PRICE_MAX;
        end else begin
            n_price = mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_id_text       <= i_line.id_text;
            r_id_length     <= i_line.id_length;
            r_symbol_text   <= i_line.symbol_text;
            r_symbol_length <= i_line.symbol_length;
            r_side          <= i_line.side;
            r_price         <= n_price;
            r_quantity      <= i_line.quantity;
        end
    end

    assign o_valid         = r_valid;
    assign o_id_text       = r_id_text;
    assign o_id_length     = r_id_length;
    assign o_symbol_text   = r_symbol_text;
    assign o_symbol_length = r_symbol_length;
    assign o_side          = r_side;
    assign o_price         = signed'(r_price);
    assign o_quantity      = signed'(r_quantity);

endmodule

// ----- rtl/fix_order_line_parser_core.sv -----
// An order goes from the edge that takes its line-ending byte through the
// finished-line register, then the output register, to the output.
// The scanner takes one byte per cycle unless stalled; each byte updates the line state.
// The input stalls only while both registers hold orders and the output is not taken.
// Reset: synchronous, active low; clears line state and both valid flags.
// Top level of the FIX order line parser; depends on fop_pkg, fop_scan, fop_out.
module fix_order_line_parser_core
    import fop_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_byte_req,
    input  logic               i_end_of_stream,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [63:0]        o_id_text,
    output logic [3:0]         o_id_length,
    output logic [63:0]        o_symbol_text,
    output logic [3:0]         o_symbol_length,
    output logic [1:0]         o_side,
    output logic signed [47:0] o_price,
    output logic signed [31:0] o_quantity
);

    logic  line_valid;
    logic  line_ready;
    t_line line;

    // Byte scanner
    fop_scan u_scan (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_byte_req      (i_byte_req),
        .i_end_of_stream (i_end_of_stream),
        .o_line_valid    (line_valid),
        .i_line_ready    (line_ready),
        .o_line          (line)
    );

    // Price finish and output register
    fop_out u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_line_valid    (line_valid),
        .o_line_ready    (line_ready),
        .i_line          (line),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_id_text       (o_id_text),
        .o_id_length     (o_id_length),
        .o_symbol_text   (o_symbol_text),
        .o_symbol_length (o_symbol_length),
        .o_side          (o_side),
        .o_price         (o_price),
        .o_quantity      (o_quantity)
    );

endmodule
